FILE: rtl/core/slpa_pkg.sv
// Shared types, codes and helper functions for the status LED priority animator.
// No dependencies; every other file of the block but slpa_if imports this package.
`default_nettype none

package slpa_pkg;

    // Operation codes of an input word
    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    // Status codes
    localparam logic [3:0] ST_NORMAL       = 4'd0;
    localparam logic [3:0] ST_CHARGING     = 4'd1;
    localparam logic [3:0] ST_LOW_BATTERY  = 4'd2;
    localparam logic [3:0] ST_SOFT_OFF     = 4'd3;
    localparam logic [3:0] ST_RADIO_WAIT   = 4'd4;
    localparam logic [3:0] ST_RADIO_CONN   = 4'd5;
    localparam logic [3:0] ST_RADIO_PAIR   = 4'd6;
    localparam logic [3:0] ST_BOOT_REQUEST = 4'd7;
    localparam logic [3:0] ST_MATRIX_FAULT = 4'd8;
    localparam logic [3:0] ST_BOOT_WAIT    = 4'd9;
    localparam logic [3:0] ST_BOOT_CDC     = 4'd10;
    localparam logic [3:0] ST_BOOT_WRITING = 4'd11;
    localparam logic [3:0] ST_BOOT_OK      = 4'd12;
    localparam logic [3:0] ST_BOOT_FAIL    = 4'd13;
    localparam logic [3:0] ST_BOOT_LOW_PWR = 4'd14;
    localparam logic [3:0] ST_INVALID      = 4'd15;

    // Configuration register indexes
    localparam logic [1:0] REG_ON_LEVEL   = 2'd0;
    localparam logic [1:0] REG_BLUE_LEVEL = 2'd1;
    localparam logic [1:0] REG_BREATH_MIN = 2'd2;
    localparam logic [1:0] REG_BREATH_MAX = 2'd3;

    localparam logic [7:0] ON_LEVEL_RST   = 8'd24;
    localparam logic [7:0] BLUE_LEVEL_RST = 8'd51;
    localparam logic [7:0] BREATH_MIN_RST = 8'd2;
    localparam logic [7:0] BREATH_MAX_RST = 8'd24;

    localparam logic [7:0] SLOT_RST = 8'd1;

    // Widest animation step the parameter range allows
    localparam int STEP_EXT_W = 7;

    // Animation period: charge 50, slow 1000, fast 250 time units per step
    typedef enum logic [1:0] {
        PER_NONE,
        PER_CHARGE,
        PER_SLOW,
        PER_FAST
    } period_t;

    typedef struct packed {
        logic       boot_active;
        logic [3:0] boot_status;
        logic [3:0] power;
        logic [3:0] radio;
        logic [3:0] system;
        logic [7:0] radio_slot;
    } chan_state_t;

    function automatic logic [2:0] boot_prio(input logic [3:0] s);
        logic [2:0] p;
        unique case (s)
            ST_BOOT_WAIT:    p = 3'd1;
            ST_BOOT_CDC:     p = 3'd2;
            ST_BOOT_OK:      p = 3'd3;
            ST_BOOT_FAIL:    p = 3'd4;
            ST_BOOT_LOW_PWR: p = 3'd5;
            ST_BOOT_WRITING: p = 3'd6;
            default:         p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [6:0] chan_prio(input logic [3:0] s);
        logic [6:0] p;
        unique case (s)
            ST_CHARGING:     p = 7'd60;
            ST_LOW_BATTERY:  p = 7'd50;
            ST_SOFT_OFF:     p = 7'd90;
            ST_RADIO_WAIT:   p = 7'd30;
            ST_RADIO_CONN:   p = 7'd20;
            ST_RADIO_PAIR:   p = 7'd40;
            ST_BOOT_REQUEST: p = 7'd70;
            ST_MATRIX_FAULT: p = 7'd80;
            default:         p = 7'd0;
        endcase
        return p;
    endfunction

    function automatic period_t period_of(input chan_state_t c);
        period_t p;
        period_t rp;
        p  = PER_NONE;
        rp = PER_NONE;
        if (!c.boot_active) begin
            if (c.power == ST_CHARGING) p = PER_CHARGE;
            else if (c.power == ST_LOW_BATTERY) p = PER_SLOW;
            else if (c.power == ST_SOFT_OFF) p = PER_FAST;
            if (c.system == ST_NORMAL) begin
                if (c.radio == ST_RADIO_WAIT) rp = PER_SLOW;
                else if (c.radio == ST_RADIO_PAIR) rp = PER_FAST;
                // take the shorter edge
                if (rp != PER_NONE &&
                    (p == PER_NONE || (rp == PER_FAST && p == PER_SLOW))) begin
                    p = rp;
                end
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/slpa_if.sv
// Valid/ready channel interfaces for the status LED priority animator.
// Input word: operation, status code, radio slot. Output word: frame and status.
`default_nettype none

interface slpa_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [3:0] status_code;
    logic [7:0] slot_id;

    modport source (output valid, operation, status_code, slot_id, input ready);
    modport sink (input valid, operation, status_code, slot_id, output ready);
endinterface

interface slpa_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_zero;
    logic [23:0] pixel_one;
    logic [23:0] pixel_two;
    logic [23:0] pixel_three;
    logic [3:0]  primary_status;
    logic        animating;
    logic        error;

    modport source (output valid, pixel_zero, pixel_one, pixel_two, pixel_three,
                    primary_status, animating, error, input ready);
    modport sink (input valid, pixel_zero, pixel_one, pixel_two, pixel_three,
                  primary_status, animating, error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/status_led_priority_animator_top.sv
// Status LED priority animator: four RGB LEDs driven from prioritized status channels.
// A result word passes the stage one and output registers once its input is accepted.
// Throughput: one word per cycle while out_ch.ready holds; the state update is applied
// at the accepting edge, the breath ramp scale runs through one multiplier per stage.
// Reset: channels normal, radio slot 1, step 0, running; levels 24/51/2/24.
// Depends on slpa_pkg, slpa_if, slpa_update, slpa_render.
`default_nettype none

module status_led_priority_animator_top #(
    parameter int BREATH_TICKS = 80
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    slpa_in_if.sink         in_ch,
    slpa_out_if.source      out_ch
);
    import slpa_pkg::*;

    localparam int STEP_W = $clog2(BREATH_TICKS);

    logic [7:0] on_level_reg;
    logic [7:0] blue_level_reg;
    logic [7:0] breath_min_reg;
    logic [7:0] breath_max_reg;

    logic              accept;
    logic              ready;
    chan_state_t       state_next;
    logic [STEP_W-1:0] step_next;
    logic              stopped_next;
    logic              err_next;

    assign in_ch.ready = ready;
    assign accept      = in_ch.valid && ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            on_level_reg   <= ON_LEVEL_RST;
            blue_level_reg <= BLUE_LEVEL_RST;
            breath_min_reg <= BREATH_MIN_RST;
            breath_max_reg <= BREATH_MAX_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ON_LEVEL:   on_level_reg   <= cfg_data;
                REG_BLUE_LEVEL: blue_level_reg <= cfg_data;
                REG_BREATH_MIN: breath_min_reg <= cfg_data;
                REG_BREATH_MAX: breath_max_reg <= cfg_data;
            endcase
        end
    end

    slpa_update #(
        .BREATH_TICKS (BREATH_TICKS)
    ) u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (in_ch.operation),
        .status_code  (in_ch.status_code),
        .slot_id      (in_ch.slot_id),
        .state_next   (state_next),
        .step_next    (step_next),
        .stopped_next (stopped_next),
        .err_next     (err_next)
    );

    slpa_render #(
        .BREATH_TICKS (BREATH_TICKS)
    ) u_render (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .ready        (ready),
        .state_next   (state_next),
        .step_next    (step_next),
        .stopped_next (stopped_next),
        .err_next     (err_next),
        .on_level     (on_level_reg),
        .blue_level   (blue_level_reg),
        .breath_min   (breath_min_reg),
        .breath_max   (breath_max_reg),
        .out_ch       (out_ch)
    );

endmodule

`default_nettype wire

FILE: rtl/core/slpa_update.sv
// Channel state registers and the set/clear/tick/stop/resume update rules.
// Depends on slpa_pkg; presents the post-update state for rendering.
`default_nettype none

module slpa_update #(
    parameter int BREATH_TICKS = 80,
    localparam int STEP_W = $clog2(BREATH_TICKS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [2:0]         operation,
    input  wire logic [3:0]         status_code,
    input  wire logic [7:0]         slot_id,
    output slpa_pkg::chan_state_t   state_next,
    output logic [STEP_W-1:0]       step_next,
    output logic                    stopped_next,
    output logic                    err_next
);
    import slpa_pkg::*;

    chan_state_t       state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              stopped_reg;

    always_comb begin
        chan_state_t cs;
        cs           = state_reg;
        step_next    = step_reg;
        stopped_next = stopped_reg;
        err_next     = 1'b0;
        unique case (operation)
            OP_SET: begin
                if (status_code == ST_INVALID) begin
                    err_next = 1'b1;
                end else if (status_code >= ST_BOOT_WAIT) begin
                    if (!state_reg.boot_active ||
                        boot_prio(status_code) > boot_prio(state_reg.boot_status)) begin
                        cs.boot_active = 1'b1;
                        cs.boot_status = status_code;
                        step_next      = '0;
                    end
                end else begin
                    cs.boot_active = 1'b0;
                    if (status_code == ST_NORMAL) begin
                        cs.power      = ST_NORMAL;
                        cs.radio      = ST_NORMAL;
                        cs.system     = ST_NORMAL;
                        cs.radio_slot = SLOT_RST;
                    end else if (status_code <= ST_SOFT_OFF) begin
                        if (chan_prio(status_code) >= chan_prio(state_reg.power))
                            cs.power = status_code;
                    end else if (status_code <= ST_RADIO_PAIR) begin
                        if (chan_prio(status_code) >= chan_prio(state_reg.radio)) begin
                            cs.radio      = status_code;
                            cs.radio_slot = slot_id;
                        end
                    end else begin
                        if (chan_prio(status_code) >= chan_prio(state_reg.system))
                            cs.system = status_code;
                    end
                    if (cs != state_reg) step_next = '0;
                end
            end
            OP_CLEAR: begin
                if (status_code >= ST_BOOT_WAIT && status_code <= ST_BOOT_LOW_PWR) begin
                    if (state_reg.boot_active && state_reg.boot_status == status_code) begin
                        cs.boot_active = 1'b0;
                        cs.boot_status = ST_BOOT_WAIT;
                        step_next      = '0;
                    end
                end else if (status_code >= ST_CHARGING && status_code <= ST_SOFT_OFF &&
                             state_reg.power == status_code) begin
                    cs.power  = ST_NORMAL;
                    step_next = '0;
                end else if (status_code >= ST_RADIO_WAIT && status_code <= ST_RADIO_PAIR &&
                             state_reg.radio == status_code) begin
                    cs.radio  = ST_NORMAL;
                    step_next = '0;
                end else if ((status_code == ST_BOOT_REQUEST ||
                              status_code == ST_MATRIX_FAULT) &&
                             state_reg.system == status_code) begin
                    cs.system = ST_NORMAL;
                    step_next = '0;
                end else if (status_code == ST_NORMAL) begin
                    cs.boot_active = 1'b0;
                    cs.power       = ST_NORMAL;
                    cs.radio       = ST_NORMAL;
                    cs.system      = ST_NORMAL;
                    cs.radio_slot  = SLOT_RST;
                    if (cs != state_reg) step_next = '0;
                end
            end
            OP_TICK: begin
                if (!stopped_reg && period_of(state_reg) != PER_NONE) begin
                    // advance modulo the breath period
                    if (step_reg == STEP_W'(BREATH_TICKS - 1)) step_next = '0;
                    else step_next = step_reg + 1'b1;
                end
            end
            OP_STOP: begin
                stopped_next = 1'b1;
                step_next    = '0;
            end
            OP_RESUME: begin
                if (stopped_reg) begin
                    stopped_next = 1'b0;
                    step_next    = '0;
                end
            end
            default: begin
            end
        endcase
        state_next = cs;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg.boot_active <= 1'b0;
            state_reg.boot_status <= ST_BOOT_WAIT;
            state_reg.power       <= ST_NORMAL;
            state_reg.radio       <= ST_NORMAL;
            state_reg.system      <= ST_NORMAL;
            state_reg.radio_slot  <= SLOT_RST;
            step_reg              <= '0;
            stopped_reg           <= 1'b0;
        end else if (accept) begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/slpa_render.sv
// Two-stage frame renderer: breath product in stage one, breath scaling,
// blink decode and pixel assembly into the output register. Depends on slpa_pkg.
`default_nettype none

module slpa_render #(
    parameter int BREATH_TICKS = 80,
    localparam int STEP_W = $clog2(BREATH_TICKS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    output logic                    ready,
    input  wire slpa_pkg::chan_state_t state_next,
    input  wire logic [STEP_W-1:0]  step_next,
    input  wire logic               stopped_next,
    input  wire logic               err_next,
    input  wire logic [7:0]         on_level,
    input  wire logic [7:0]         blue_level,
    input  wire logic [7:0]         breath_min,
    input  wire logic [7:0]         breath_max,
    slpa_out_if.source              out_ch
);
    import slpa_pkg::*;

    localparam int HALF        = BREATH_TICKS / 2;
    localparam int BREATH_DIV  = HALF - 1;
    localparam int RECIP_SH    = 20;
    localparam int RECIP_W     = RECIP_SH + 1;
    // exact for every product the breath ramp can produce
    localparam int RECIP       = ((1 << RECIP_SH) + BREATH_DIV - 1) / BREATH_DIV;
    localparam int PROD_W      = 8 + STEP_W;
    localparam int SCALE_W     = PROD_W + RECIP_W;
    localparam int DIV5_MUL    = 205;
    localparam int DIV5_SH     = 10;

    // stage one
    logic              s1_valid_reg;
    chan_state_t       s1_state_reg;
    logic [STEP_W-1:0] s1_step_reg;
    logic              s1_stopped_reg;
    logic              s1_err_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [7:0]        s1_lo_reg;

    // output register
    logic        out_valid_reg;
    logic [23:0] pix0_reg, pix1_reg, pix2_reg, pix3_reg;
    logic [3:0]  primary_reg;
    logic        animating_reg;
    logic        error_reg;

    logic              s2_ready;
    logic              s1_move;
    logic [7:0]        lo_next;
    logic [STEP_W-1:0] pos_next;
    logic [PROD_W-1:0] prod_next;

    assign s2_ready = !out_valid_reg || out_ch.ready;
    assign ready    = !s1_valid_reg || s2_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    always_comb begin
        logic [7:0] diff;
        lo_next  = (breath_min < breath_max) ? breath_min : breath_max;
        diff     = breath_max - lo_next;
        // fold the step onto the rising half of the ramp
        pos_next = (step_next < STEP_W'(HALF)) ? step_next
                                              : STEP_W'(BREATH_TICKS - 1) - step_next;
        prod_next = PROD_W'(diff) * PROD_W'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) s1_valid_reg <= 1'b1;
            else if (s1_move) s1_valid_reg <= 1'b0;
            if (s1_move) out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_state_reg   <= state_next;
            s1_step_reg    <= step_next;
            s1_stopped_reg <= stopped_next;
            s1_err_reg     <= err_next;
            s1_prod_reg    <= prod_next;
            s1_lo_reg      <= lo_next;
        end
    end

    // frame from the stage one word
    logic [23:0] pix_c [4];
    logic [3:0]  primary_c;
    logic        animating_c;

    always_comb begin
        logic [SCALE_W-1:0]       scaled;
        logic [7:0]               level;
        logic [STEP_EXT_W-1:0]    step7;
        logic [STEP_EXT_W+7:0]    fifth_prod;
        logic [STEP_EXT_W-1:0]    fifth;
        logic                     slow_on;
        logic                     fast_on;
        period_t                  per;
        logic [1:0]               idx;
        logic [23:0]              c_red;
        logic [23:0]              c_blue;
        logic [6:0]               best_p;
        logic [3:0]               chans [3];

        scaled     = SCALE_W'(s1_prod_reg) * SCALE_W'(RECIP);
        level      = s1_lo_reg + scaled[RECIP_SH +: 8];
        step7      = STEP_EXT_W'(s1_step_reg);
        fifth_prod = (STEP_EXT_W + 8)'(step7) * (STEP_EXT_W + 8)'(DIV5_MUL);
        fifth      = STEP_EXT_W'(fifth_prod >> DIV5_SH);
        per        = period_of(s1_state_reg);
        c_red      = {on_level, 8'd0, 8'd0};
        c_blue     = {8'd0, 8'd0, blue_level};

        // blink phases for elapsed time step * period
        unique case (per)
            PER_SLOW: begin
                slow_on = !step7[0];
                fast_on = 1'b1;
            end
            PER_FAST: begin
                slow_on = !step7[2];
                fast_on = !step7[0];
            end
            PER_CHARGE: begin
                slow_on = !fifth[2];
                fast_on = !fifth[0];
            end
            default: begin
                slow_on = 1'b1;
                fast_on = 1'b1;
            end
        endcase

        if (s1_state_reg.radio_slot == 8'd2) idx = 2'd1;
        else if (s1_state_reg.radio_slot == 8'd3) idx = 2'd0;
        else idx = 2'd2;

        for (int i = 0; i < 4; i++) pix_c[i] = 24'd0;

        if (!s1_stopped_reg) begin
            if (s1_state_reg.boot_active) begin
                unique case (s1_state_reg.boot_status)
                    ST_BOOT_WAIT, ST_BOOT_OK: begin
                        for (int i = 0; i < 3; i++) pix_c[i] = {8'd0, on_level, 8'd0};
                    end
                    ST_BOOT_CDC: begin
                        for (int i = 0; i < 3; i++) pix_c[i] = {on_level, 8'd0, on_level};
                    end
                    ST_BOOT_WRITING: begin
                        for (int i = 0; i < 3; i++) pix_c[i] = {on_level, on_level, 8'd0};
                    end
                    ST_BOOT_FAIL: begin
                        for (int i = 0; i < 3; i++) pix_c[i] = c_red;
                    end
                    ST_BOOT_LOW_PWR: pix_c[3] = c_red;
                    default: begin
                    end
                endcase
            end else begin
                if (s1_state_reg.power == ST_CHARGING) pix_c[3] = {8'd0, level, level};
                else if (s1_state_reg.power == ST_LOW_BATTERY && slow_on) pix_c[3] = c_red;
                else if (s1_state_reg.power == ST_SOFT_OFF && fast_on) pix_c[3] = c_red;

                if (s1_state_reg.radio == ST_RADIO_WAIT) begin
                    if (slow_on) pix_c[idx] = c_blue;
                end else if (s1_state_reg.radio == ST_RADIO_CONN) begin
                    pix_c[idx] = {8'd0, on_level, 8'd0};
                end else if (s1_state_reg.radio == ST_RADIO_PAIR) begin
                    if (fast_on) pix_c[idx] = c_blue;
                end

                // system faults cover the three radio LEDs
                if (s1_state_reg.system == ST_BOOT_REQUEST) begin
                    for (int i = 0; i < 3; i++) pix_c[i] = {on_level, 8'd0, on_level};
                end else if (s1_state_reg.system == ST_MATRIX_FAULT) begin
                    for (int i = 0; i < 3; i++) pix_c[i] = {on_level, on_level, 8'd0};
                end
            end
        end

        chans[0]  = s1_state_reg.power;
        chans[1]  = s1_state_reg.radio;
        chans[2]  = s1_state_reg.system;
        best_p    = 7'd0;
        primary_c = ST_NORMAL;
        if (s1_state_reg.boot_active) begin
            primary_c = s1_state_reg.boot_status;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (chan_prio(chans[i]) > best_p) begin
                    best_p    = chan_prio(chans[i]);
                    primary_c = chans[i];
                end
            end
        end
        animating_c = !s1_stopped_reg && per != PER_NONE;
    end

    always_ff @(posedge clk) begin
        if (s1_move) begin
            pix0_reg      <= pix_c[0];
            pix1_reg      <= pix_c[1];
            pix2_reg      <= pix_c[2];
            pix3_reg      <= pix_c[3];
            primary_reg   <= primary_c;
            animating_reg <= animating_c;
            error_reg     <= s1_err_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pixel_zero     = pix0_reg;
    assign out_ch.pixel_one      = pix1_reg;
    assign out_ch.pixel_two      = pix2_reg;
    assign out_ch.pixel_three    = pix3_reg;
    assign out_ch.primary_status = primary_reg;
    assign out_ch.animating      = animating_reg;
    assign out_ch.error          = error_reg;

endmodule

`default_nettype wire

FILE: sim/status_led_frame_check.sv
// Frame checker for the status LED priority animator: follows the channel state
// from accepted input words and compares each output word with its prediction.
// Depends on slpa_pkg and the slpa_in_if / slpa_out_if interfaces.
module status_led_frame_check (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    slpa_in_if              in_ch,
    slpa_out_if             out_ch,
    output int              mismatches,
    output int              outstanding,
    output int              frames_checked
);

    import slpa_pkg::*;

    localparam int STEP_WRAP   = 80;
    localparam int BREATH_HALF = STEP_WRAP / 2;
    localparam int CHARGE_EDGE = 50;
    localparam int SLOW_EDGE   = 1000;
    localparam int FAST_EDGE   = 250;

    typedef struct packed {
        logic [23:0] led0;
        logic [23:0] led1;
        logic [23:0] led2;
        logic [23:0] led3;
        logic [3:0]  primary;
        logic        animating;
        logic        error;
    } frame_t;

    logic [7:0] on_lvl;
    logic [7:0] blue_lvl;
    logic [7:0] br_min;
    logic [7:0] br_max;
    logic       boot_on;
    logic       halted;
    logic [3:0] boot_code;
    logic [3:0] power_st;
    logic [3:0] radio_st;
    logic [3:0] system_st;
    logic [7:0] slot_sel;
    int         step;

    frame_t frames_due[$];
    frame_t got;
    frame_t want;

    function automatic int boot_rank(input logic [3:0] s);
        case (s)
            ST_BOOT_WAIT:    return 1;
            ST_BOOT_CDC:     return 2;
            ST_BOOT_OK:      return 3;
            ST_BOOT_FAIL:    return 4;
            ST_BOOT_LOW_PWR: return 5;
            ST_BOOT_WRITING: return 6;
            default:         return 0;
        endcase
    endfunction

    function automatic int chan_rank(input logic [3:0] s);
        case (s)
            ST_NORMAL:       return 0;
            ST_CHARGING:     return 60;
            ST_LOW_BATTERY:  return 50;
            ST_SOFT_OFF:     return 90;
            ST_RADIO_WAIT:   return 30;
            ST_RADIO_CONN:   return 20;
            ST_RADIO_PAIR:   return 40;
            ST_BOOT_REQUEST: return 70;
            ST_MATRIX_FAULT: return 80;
            default:         return -1;
        endcase
    endfunction

    // Time units per animation step; zero when no channel state animates
    function automatic int anim_period();
        int p;
        int rp;
        p  = 0;
        rp = 0;
        if (boot_on)
            return 0;
        if (power_st == ST_CHARGING) p = CHARGE_EDGE;
        else if (power_st == ST_LOW_BATTERY) p = SLOW_EDGE;
        else if (power_st == ST_SOFT_OFF) p = FAST_EDGE;
        // radio blinks only count while the system channel is quiet
        if (system_st == ST_NORMAL) begin
            if (radio_st == ST_RADIO_WAIT) rp = SLOW_EDGE;
            else if (radio_st == ST_RADIO_PAIR) rp = FAST_EDGE;
            if (rp != 0 && (p == 0 || rp < p))
                p = rp;
        end
        return p;
    endfunction

    function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return {r, g, b};
    endfunction

    function automatic bit lit(input int elapsed, input int span);
        return ((elapsed / span) % 2) == 0;
    endfunction

    function automatic int breath_level(input int idx);
        int s;
        int pos;
        int lo;
        int hi;
        s   = idx % STEP_WRAP;
        pos = (s < BREATH_HALF) ? s : STEP_WRAP - s - 1;
        hi  = int'(br_max);
        lo  = (int'(br_min) < hi) ? int'(br_min) : hi;
        return lo + ((hi - lo) * pos) / (BREATH_HALF - 1);
    endfunction

    function automatic logic [20:0] chan_snap();
        return {boot_on, power_st, radio_st, system_st, slot_sel};
    endfunction

    function automatic void drop_channels();
        boot_on   = 1'b0;
        power_st  = ST_NORMAL;
        radio_st  = ST_NORMAL;
        system_st = ST_NORMAL;
        slot_sel  = SLOT_RST;
    endfunction

    function automatic frame_t draw_frame();
        frame_t      f;
        logic [23:0] px [0:3];
        logic [23:0] all3;
        logic [3:0]  chans [0:2];
        logic        use3;
        int          el;
        int          idx;
        int          b;
        int          bp;
        f    = '0;
        use3 = 1'b0;
        all3 = '0;
        foreach (px[i])
            px[i] = '0;
        if (!halted) begin
            if (boot_on) begin
                use3 = 1'b1;
                case (boot_code)
                    ST_BOOT_WAIT, ST_BOOT_OK: all3 = rgb(8'd0, on_lvl, 8'd0);
                    ST_BOOT_CDC:              all3 = rgb(on_lvl, 8'd0, on_lvl);
                    ST_BOOT_WRITING:          all3 = rgb(on_lvl, on_lvl, 8'd0);
                    ST_BOOT_FAIL:             all3 = rgb(on_lvl, 8'd0, 8'd0);
                    ST_BOOT_LOW_PWR:
                    begin
                        use3  = 1'b0;
                        px[3] = rgb(on_lvl, 8'd0, 8'd0);
                    end
                    default:                  use3 = 1'b0;
                endcase
            end
            else begin
                el = step * anim_period();
                if (power_st == ST_CHARGING) begin
                    b     = breath_level(el / CHARGE_EDGE);
                    px[3] = rgb(8'd0, 8'(b), 8'(b));
                end
                else if (power_st == ST_LOW_BATTERY) begin
                    if (lit(el, SLOW_EDGE)) px[3] = rgb(on_lvl, 8'd0, 8'd0);
                end
                else if (power_st == ST_SOFT_OFF) begin
                    if (lit(el, FAST_EDGE)) px[3] = rgb(on_lvl, 8'd0, 8'd0);
                end
                // slot 2 on LED 1, slot 3 on LED 0, anything else on LED 2
                idx = (slot_sel == 8'd2) ? 1 : ((slot_sel == 8'd3) ? 0 : 2);
                if (radio_st == ST_RADIO_WAIT) begin
                    if (lit(el, SLOW_EDGE)) px[idx] = rgb(8'd0, 8'd0, blue_lvl);
                end
                else if (radio_st == ST_RADIO_CONN) begin
                    px[idx] = rgb(8'd0, on_lvl, 8'd0);
                end
                else if (radio_st == ST_RADIO_PAIR) begin
                    if (lit(el, FAST_EDGE)) px[idx] = rgb(8'd0, 8'd0, blue_lvl);
                end
                if (system_st == ST_BOOT_REQUEST) begin
                    use3 = 1'b1;
                    all3 = rgb(on_lvl, 8'd0, on_lvl);
                end
                else if (system_st == ST_MATRIX_FAULT) begin
                    use3 = 1'b1;
                    all3 = rgb(on_lvl, on_lvl, 8'd0);
                end
            end
            if (use3) begin
                px[0] = all3;
                px[1] = all3;
                px[2] = all3;
            end
        end
        f.led0 = px[0];
        f.led1 = px[1];
        f.led2 = px[2];
        f.led3 = px[3];
        if (boot_on) begin
            f.primary = boot_code;
        end
        else begin
            chans[0]  = power_st;
            chans[1]  = radio_st;
            chans[2]  = system_st;
            f.primary = ST_NORMAL;
            bp        = 0;
            foreach (chans[i]) begin
                if (chan_rank(chans[i]) > bp) begin
                    bp        = chan_rank(chans[i]);
                    f.primary = chans[i];
                end
            end
        end
        f.animating = !halted && anim_period() != 0;
        return f;
    endfunction

    // Advance the channel state by one input word and return the frame it yields
    function automatic frame_t apply_word(input logic [2:0] op, input logic [3:0] code,
                                          input logic [7:0] slot);
        frame_t      f;
        logic [20:0] prior;
        logic        err;
        err   = 1'b0;
        prior = chan_snap();
        case (op)
            OP_SET:
            begin
                if (code == ST_INVALID) begin
                    err = 1'b1;
                end
                else if (code >= ST_BOOT_WAIT) begin
                    if (!boot_on || boot_rank(code) > boot_rank(boot_code)) begin
                        boot_on   = 1'b1;
                        boot_code = code;
                        step      = 0;
                    end
                end
                else begin
                    boot_on = 1'b0;
                    if (code == ST_NORMAL) begin
                        drop_channels();
                    end
                    else if (code <= ST_SOFT_OFF) begin
                        if (chan_rank(code) >= chan_rank(power_st)) power_st = code;
                    end
                    else if (code <= ST_RADIO_PAIR) begin
                        if (chan_rank(code) >= chan_rank(radio_st)) begin
                            radio_st = code;
                            slot_sel = slot;
                        end
                    end
                    else if (chan_rank(code) >= chan_rank(system_st)) begin
                        system_st = code;
                    end
                    if (chan_snap() != prior)
                        step = 0;
                end
            end
            OP_CLEAR:
            begin
                if (code >= ST_BOOT_WAIT && code <= ST_BOOT_LOW_PWR) begin
                    if (boot_on && boot_code == code) begin
                        boot_on   = 1'b0;
                        boot_code = ST_BOOT_WAIT;
                        step      = 0;
                    end
                end
                else if (code >= ST_CHARGING && code <= ST_SOFT_OFF && power_st == code) begin
                    power_st = ST_NORMAL;
                    step     = 0;
                end
                else if (code >= ST_RADIO_WAIT && code <= ST_RADIO_PAIR
                         && radio_st == code) begin
                    radio_st = ST_NORMAL;
                    step     = 0;
                end
                else if ((code == ST_BOOT_REQUEST || code == ST_MATRIX_FAULT)
                         && system_st == code) begin
                    system_st = ST_NORMAL;
                    step      = 0;
                end
                else if (code == ST_NORMAL) begin
                    drop_channels();
                    if (chan_snap() != prior)
                        step = 0;
                end
            end
            OP_TICK:
            begin
                if (!halted && anim_period() != 0)
                    step = (step + 1) % STEP_WRAP;
            end
            OP_STOP:
            begin
                halted = 1'b1;
                step   = 0;
            end
            OP_RESUME:
            begin
                if (halted) begin
                    halted = 1'b0;
                    step   = 0;
                end
            end
            default:
            begin
            end
        endcase
        f       = draw_frame();
        f.error = err;
        return f;
    endfunction

    task automatic note_mismatch(input string field, input logic [23:0] seen,
                                 input logic [23:0] predicted);
        mismatches++;
        $display("frame %0d: %s is %h, predicted %h", frames_checked, field, seen,
                 predicted);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            on_lvl         = ON_LEVEL_RST;
            blue_lvl       = BLUE_LEVEL_RST;
            br_min         = BREATH_MIN_RST;
            br_max         = BREATH_MAX_RST;
            boot_code      = ST_BOOT_WAIT;
            step           = 0;
            halted         = 1'b0;
            drop_channels();
            frames_due.delete();
            outstanding    = 0;
            mismatches     = 0;
            frames_checked = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_ON_LEVEL:   on_lvl   = cfg_data;
                    REG_BLUE_LEVEL: blue_lvl = cfg_data;
                    REG_BREATH_MIN: br_min   = cfg_data;
                    REG_BREATH_MAX: br_max   = cfg_data;
                    default:        ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.pixel_zero, out_ch.pixel_one, out_ch.pixel_two,
                        out_ch.pixel_three, out_ch.primary_status, out_ch.animating,
                        out_ch.error};
                if (frames_due.size() == 0) begin
                    note_mismatch("word with no prediction, led 0", got.led0, '0);
                end
                else begin
                    want = frames_due.pop_front();
                    if (got.led0 !== want.led0) note_mismatch("led 0", got.led0, want.led0);
                    if (got.led1 !== want.led1) note_mismatch("led 1", got.led1, want.led1);
                    if (got.led2 !== want.led2) note_mismatch("led 2", got.led2, want.led2);
                    if (got.led3 !== want.led3) note_mismatch("led 3", got.led3, want.led3);
                    if (got.primary !== want.primary)
                        note_mismatch("primary_status", 24'(got.primary), 24'(want.primary));
                    if (got.animating !== want.animating)
                        note_mismatch("animating", 24'(got.animating), 24'(want.animating));
                    if (got.error !== want.error)
                        note_mismatch("error", 24'(got.error), 24'(want.error));
                end
                frames_checked++;
            end
            if (in_ch.valid && in_ch.ready)
                frames_due.push_back(apply_word(in_ch.operation, in_ch.status_code,
                                                in_ch.slot_id));
            outstanding = frames_due.size();
        end
    end

endmodule

FILE: sim/status_led_priority_animator_top_test.sv
// Testbench top for the status LED priority animator: drives scripted and random
// words and level settings, and gives the verdict from the frame checker.
// Depends on slpa_pkg, slpa_if, status_led_priority_animator_top, status_led_frame_check.
module status_led_priority_animator_top_test;

    import slpa_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_WORDS = 240;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Scripted words: {operation, status, slot}
    localparam logic [14:0] SCRIPT [26] = '{
        {OP_SET,      ST_INVALID,      8'h00},
        {OP_SET,      ST_CHARGING,     8'hFF},
        {OP_TICK,     ST_NORMAL,       8'h00},
        {OP_SET,      ST_LOW_BATTERY,  8'h00},
        {OP_SET,      ST_SOFT_OFF,     8'h00},
        {OP_CLEAR,    ST_LOW_BATTERY,  8'h00},
        {OP_SET,      ST_RADIO_WAIT,   8'hFF},
        {OP_TICK,     ST_INVALID,      8'hFF},
        {OP_SET,      ST_RADIO_PAIR,   8'h02},
        {OP_SET,      ST_RADIO_CONN,   8'h03},
        {OP_SET,      ST_MATRIX_FAULT, 8'h00},
        {OP_STOP,     ST_NORMAL,       8'h00},
        {OP_STOP,     ST_NORMAL,       8'h00},
        {OP_TICK,     ST_NORMAL,       8'h00},
        {OP_RESUME,   ST_NORMAL,       8'h00},
        {OP_RESUME,   ST_NORMAL,       8'h00},
        {OP_QUERY,    ST_INVALID,      8'hAA},
        {OP_SPARE_LO, ST_CHARGING,     8'h55},
        {OP_SPARE_HI, ST_BOOT_WAIT,    8'h00},
        {OP_SET,      ST_BOOT_WAIT,    8'h00},
        {OP_SET,      ST_BOOT_WRITING, 8'h00},
        {OP_SET,      ST_BOOT_CDC,     8'h00},
        {OP_CLEAR,    ST_BOOT_WRITING, 8'h00},
        {OP_SET,      ST_BOOT_LOW_PWR, 8'h00},
        {OP_CLEAR,    ST_INVALID,      8'h00},
        {OP_CLEAR,    ST_NORMAL,       8'h00}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       gaps_on;
    int         cycles = 0;
    int         words_sent;
    int         scripted;
    int         level_sets;
    int         mismatches;
    int         outstanding;
    int         frames_checked;

    slpa_in_if  in_ch ();
    slpa_out_if out_ch ();

    status_led_priority_animator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    status_led_frame_check frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .frames_checked (frames_checked)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side stalls at random while gaps are on
    always @(negedge clk) begin
        if (rst_n)
            out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 14);
    end

    function automatic logic [3:0] pick_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 4'($urandom_range(ST_NORMAL, ST_MATRIX_FAULT));
        else if (r < 90)
            return 4'($urandom_range(ST_BOOT_WAIT, ST_BOOT_LOW_PWR));
        return ST_INVALID;
    endfunction

    function automatic logic [7:0] pick_slot();
        if ($urandom_range(0, 99) < 75)
            return 8'($urandom_range(1, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // Starts and ends at a falling edge; holds the word until it is taken
    task automatic push_word(input logic [2:0] op, input logic [3:0] code,
                             input logic [7:0] slot);
        while (gaps_on && $urandom_range(0, 99) < 14) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.status_code <= code;
        in_ch.slot_id     <= slot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_levels(input logic [7:0] on_val, input logic [7:0] blue_val,
                               input logic [7:0] min_val, input logic [7:0] max_val);
        logic [7:0] vals [4];
        vals = '{on_val, blue_val, min_val, max_val};
        drain_results();
        foreach (vals[i]) begin
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        level_sets++;
    endtask

    // Episodes: a few set/clear words, then ticks with rare stop/resume/query/spare words
    task automatic random_phase(input int count);
        int goal;
        int burst;
        int r;
        goal = words_sent + count;
        while (words_sent < goal) begin
            if ($urandom_range(0, 99) < 30)
                push_word(OP_RESUME, pick_status(), pick_slot());
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 99) < 70)
                    push_word(OP_SET, pick_status(), pick_slot());
                else
                    push_word(OP_CLEAR, pick_status(), pick_slot());
            end
            burst = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 100)
                                                 : $urandom_range(0, 12);
            repeat (burst) begin
                r = $urandom_range(0, 99);
                if (r < 90)
                    push_word(OP_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                else if (r < 93)
                    push_word(OP_QUERY, pick_status(), pick_slot());
                else if (r < 95)
                    push_word(OP_STOP, pick_status(), pick_slot());
                else if (r < 98)
                    push_word(OP_RESUME, pick_status(), pick_slot());
                else if (r < 99)
                    push_word(OP_SPARE_LO, pick_status(), pick_slot());
                else
                    push_word(OP_SPARE_HI, pick_status(), pick_slot());
            end
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = REG_ON_LEVEL;
        cfg_data          = 8'd0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_QUERY;
        in_ch.status_code = ST_NORMAL;
        in_ch.slot_id     = 8'd0;
        out_ch.ready      = 1'b0;
        gaps_on           = 1'b1;
        words_sent        = 0;
        level_sets        = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
            push_word(SCRIPT[i][14:12], SCRIPT[i][11:8], SCRIPT[i][7:0]);
        scripted = words_sent;
        random_phase(PHASE_WORDS);

        load_levels(8'd255, 8'd255, 8'd0, 8'd255);
        random_phase(PHASE_WORDS);

        // no stalls on either side for this stretch
        load_levels(8'd0, 8'd0, 8'd0, 8'd0);
        gaps_on <= 1'b0;
        random_phase(PHASE_WORDS);

        // breath floor above ceiling
        load_levels(8'd200, 8'd1, 8'd40, 8'd10);
        gaps_on <= 1'b1;
        random_phase(PHASE_WORDS);

        load_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_phase(PHASE_WORDS);

        load_levels(8'd1, 8'd255, 8'd255, 8'd255);
        random_phase(PHASE_WORDS);

        drain_results();
        $display("Sent %0d words (%0d scripted, rest in set/clear episodes with tick runs)",
                 words_sent, scripted);
        $display("under %0d level settings; %0d frames compared, %0d mismatches",
                 level_sets, frames_checked, mismatches);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/slpa_pkg.sv
rtl/core/slpa_if.sv
rtl/core/slpa_update.sv
rtl/core/slpa_render.sv
rtl/core/status_led_priority_animator_top.sv
sim/status_led_frame_check.sv
sim/status_led_priority_animator_top_test.sv
